FILE: rtl/sltt_pkg.sv
// Shared types for the session LRU tag table: command and result payloads,
// the search probe that walks the cell chain, and the write broadcast.
// No dependencies.
package sltt_pkg;

  localparam int unsigned SESSION_W = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned OUT_IDX_W = 6;

  typedef struct packed {
    logic signed [SESSION_W-1:0] session_id;
    logic [TIME_W-1:0]           arrival_time;
  } cmd_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 newly_claimed;
    logic                 was_evicted;
  } result_t;

  // Running search state carried from cell to cell. Entry numbers travel
  // beside it, since their width follows the table depth.
  typedef struct packed {
    logic                 valid;
    logic [SESSION_W-1:0] tag;
    logic [TIME_W-1:0]    now;
    logic                 hit;
    logic                 have_free;
    logic                 have_old;
    logic [TIME_W-1:0]    old_time;
  } probe_t;

  // Update broadcast to every cell; only the addressed cell takes it.
  typedef struct packed {
    logic                 en;
    logic                 claim;
    logic [SESSION_W-1:0] tag;
    logic [TIME_W-1:0]    now;
  } write_t;

endpackage

FILE: rtl/session_lru_tag_table_core.sv
// Top level of the session LRU tag table: command intake, the chain of entry
// cells, and the hit / claim / evict decision. Depends on sltt_pkg and sltt_cell.
//
// A command is taken when start is high and busy is low. Its probe walks the
// row of NUM_ENTRIES cells at one cell per cycle; the outcome is registered
// after the last cell, and commands are handled one at a time. The result
// appears on result for one cycle with done high and must be taken then;
// busy falls in that same cycle, so the next command can be transferred right
// away. Reset clears every entry's valid bit at once, and no clearing pass is
// needed. When NUM_ENTRIES exceeds 64, entry_index carries the low six bits of
// the entry number.
module session_lru_tag_table_core import sltt_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  localparam int unsigned IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned WIDE_W = IDX_W + OUT_IDX_W;

  logic accept;

  probe_t           probe    [NUM_ENTRIES+1];
  logic [IDX_W-1:0] hit_idx  [NUM_ENTRIES+1];
  logic [IDX_W-1:0] free_idx [NUM_ENTRIES+1];
  logic [IDX_W-1:0] old_idx  [NUM_ENTRIES+1];
  logic [NUM_ENTRIES:0] probe_valids;

  probe_t           probe_head;
  probe_t           probe_head_next;
  probe_t           probe_end;

  write_t           wr;
  write_t           wr_next;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] pick_idx;
  logic [WIDE_W-1:0] pick_wide;
  result_t          result_next;

  assign accept = start && !busy;

  always_comb begin
    probe_head_next           = '0;
    probe_head_next.valid     = accept;
    probe_head_next.tag       = cmd.session_id;
    probe_head_next.now       = cmd.arrival_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_head <= '0;
    end else begin
      probe_head <= probe_head_next;
    end
  end

  assign probe[0]    = probe_head;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;
  assign old_idx[0]  = '0;

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    sltt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .probe_in     (probe[k]),
      .hit_idx_in   (hit_idx[k]),
      .free_idx_in  (free_idx[k]),
      .old_idx_in   (old_idx[k]),
      .probe_out    (probe[k+1]),
      .hit_idx_out  (hit_idx[k+1]),
      .free_idx_out (free_idx[k+1]),
      .old_idx_out  (old_idx[k+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

  for (genvar k = 0; k <= NUM_ENTRIES; k++) begin : g_valids
    assign probe_valids[k] = probe[k].valid;
  end

  assign probe_end = probe[NUM_ENTRIES];

  // A hit refreshes the time only; otherwise the first free entry is claimed,
  // and with the table full the oldest entry is replaced.
  always_comb begin
    wr_next       = '0;
    wr_next.en    = probe_end.valid;
    wr_next.tag   = probe_end.tag;
    wr_next.now   = probe_end.now;
    result_next   = '0;
    if (probe_end.hit) begin
      pick_idx = hit_idx[NUM_ENTRIES];
    end else if (probe_end.have_free) begin
      pick_idx                  = free_idx[NUM_ENTRIES];
      wr_next.claim             = 1'b1;
      result_next.newly_claimed = 1'b1;
    end else begin
      pick_idx                  = old_idx[NUM_ENTRIES];
      wr_next.claim             = 1'b1;
      result_next.newly_claimed = 1'b1;
      result_next.was_evicted   = 1'b1;
    end
    pick_wide               = WIDE_W'(pick_idx);
    result_next.entry_index = pick_wide[OUT_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    wr_idx <= pick_idx;
    result <= result_next;
    if (rst) begin
      wr   <= '0;
      done <= 1'b0;
      busy <= 1'b0;
    end else begin
      wr   <= wr_next;
      done <= probe_end.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (probe_end.valid) begin
        busy <= 1'b0;
      end
    end
  end

  // Only one command is ever in flight along the chain.
  a_single_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(probe_valids))
    else $error("more than one probe in the cell chain");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && probe_head.valid)
    else $error("accepted command did not enter the chain");

  a_done_write: assert property (@(posedge clk) disable iff (rst)
    done |-> wr.en && !busy)
    else $error("result without the matching table update");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result appeared with no command in flight");

  a_claim_flags: assert property (@(posedge clk) disable iff (rst)
    done && result.was_evicted |-> result.newly_claimed && wr.claim)
    else $error("eviction reported without a claim");

endmodule

FILE: rtl/sltt_cell.sv
// One table entry of the session LRU tag table and its stage of the search chain.
// Depends on sltt_pkg for the probe and write types.
module sltt_cell import sltt_pkg::*; #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  probe_t           probe_in,
  input  logic [IDX_W-1:0] hit_idx_in,
  input  logic [IDX_W-1:0] free_idx_in,
  input  logic [IDX_W-1:0] old_idx_in,
  output probe_t           probe_out,
  output logic [IDX_W-1:0] hit_idx_out,
  output logic [IDX_W-1:0] free_idx_out,
  output logic [IDX_W-1:0] old_idx_out,
  input  write_t           wr,
  input  logic [IDX_W-1:0] wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                 valid;
  logic [SESSION_W-1:0] session;
  logic [TIME_W-1:0]    last;

  probe_t           probe_next;
  logic [IDX_W-1:0] hit_idx_next;
  logic [IDX_W-1:0] free_idx_next;
  logic [IDX_W-1:0] old_idx_next;

  // Once a hit is found the probe passes through untouched, so the first
  // matching entry wins.
  always_comb begin
    probe_next    = probe_in;
    hit_idx_next  = hit_idx_in;
    free_idx_next = free_idx_in;
    old_idx_next  = old_idx_in;
    if (probe_in.valid && !probe_in.hit) begin
      if (!valid) begin
        if (!probe_in.have_free) begin
          probe_next.have_free = 1'b1;
          free_idx_next        = MY_IDX;
        end
      end else if (session == probe_in.tag) begin
        probe_next.hit = 1'b1;
        hit_idx_next   = MY_IDX;
      end else if (!probe_in.have_old || (last < probe_in.old_time)) begin
        probe_next.have_old = 1'b1;
        probe_next.old_time = last;
        old_idx_next        = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_out  <= hit_idx_next;
    free_idx_out <= free_idx_next;
    old_idx_out  <= old_idx_next;
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == MY_IDX)) begin
      last <= wr.now;
      if (wr.claim) begin
        session <= wr.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.claim && (wr_idx == MY_IDX)) begin
      valid <= 1'b1;
    end
  end

endmodule

FILE: dv/session_lru_tag_table_core_test.sv
// Self-checking testbench for session_lru_tag_table_core: drives lookup commands,
// predicts hit / claim / evict outcomes with a local table model, and checks results.
// Depends on sltt_pkg and the RTL of session_lru_tag_table_core.
`timescale 1ns / 1ps

module session_lru_tag_table_core_test;
  import sltt_pkg::*;

  localparam int NUM_ENTRIES = 64;
  localparam int POOL_SIZE   = 80;
  localparam int RANDOM_CMDS = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    cmd_t c;
    bit   drain_first;
  } lookup_req_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    done;
  result_t result;

  // Local copy of the tag table.
  bit                   tbl_valid [NUM_ENTRIES];
  logic [SESSION_W-1:0] tbl_session [NUM_ENTRIES];
  logic [TIME_W-1:0]    tbl_last [NUM_ENTRIES];

  lookup_req_t cmd_backlog[$];
  result_t     lookup_due[$];
  int          accepted_count = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  session_lru_tag_table_core #(.NUM_ENTRIES(NUM_ENTRIES)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Looks a session up in the local table and applies the same update the block does.
  function automatic result_t predict_lookup(cmd_t c);
    result_t r;
    bit      have_free;
    bit      have_old;
    int      free_idx;
    int      old_idx;
    int      pick;
    r = '0;
    have_free = 1'b0;
    have_old = 1'b0;
    free_idx = 0;
    old_idx = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_idx = i;
        end
      end else if (tbl_session[i] == $unsigned(c.session_id)) begin
        tbl_last[i] = c.arrival_time;
        r.entry_index = OUT_IDX_W'(i);
        return r;
      end else if (!have_old || tbl_last[i] < tbl_last[old_idx]) begin
        have_old = 1'b1;
        old_idx = i;
      end
    end
    pick = have_free ? free_idx : old_idx;
    tbl_valid[pick] = 1'b1;
    tbl_session[pick] = c.session_id;
    tbl_last[pick] = c.arrival_time;
    r.entry_index = OUT_IDX_W'(pick);
    r.newly_claimed = 1'b1;
    r.was_evicted = !have_free;
    return r;
  endfunction

  // Sender idle chance in percent, stepped through phases by transfer count.
  function automatic int sender_idle_pct(int n);
    if (n < 100) return 0;
    if (n < 200) return 52;
    if (n < 300) return 0;
    return 38;
  endfunction

  task automatic add_cmd(logic [SESSION_W-1:0] sid, logic [TIME_W-1:0] t, bit drain);
    lookup_req_t q;
    q.c.session_id = sid;
    q.c.arrival_time = t;
    q.drain_first = drain;
    cmd_backlog.push_back(q);
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver: a command stays on the port until it is transferred.
  always @(posedge clk) begin
    lookup_req_t next_req;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        lookup_due.push_back(predict_lookup(cmd));
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0 &&
            !(cmd_backlog[0].drain_first && lookup_due.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct(accepted_count)) begin
          next_req = cmd_backlog.pop_front();
          start <= 1'b1;
          cmd   <= next_req.c;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (lookup_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %0d claim %0b evict %0b",
                 $time, result.entry_index, result.newly_claimed, result.was_evicted);
        error_count++;
      end else begin
        want = lookup_due.pop_front();
        report_field("entry_index", 32'(want.entry_index), 32'(result.entry_index));
        report_field("newly_claimed", 32'(want.newly_claimed), 32'(result.newly_claimed));
        report_field("was_evicted", 32'(want.was_evicted), 32'(result.was_evicted));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [SESSION_W-1:0] pool [POOL_SIZE];
    logic [SESSION_W-1:0] sid;
    logic [TIME_W-1:0]    clock_ms;
    int                   roll;

    // Directed part: field extremes, hits on a partly filled table, equal and
    // backwards times, alternating bit patterns.
    add_cmd(32'h0000_0000, 48'h0000_0000_0000, 1'b0);
    add_cmd(32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    add_cmd(32'h8000_0000, 48'h0000_0000_0001, 1'b0);
    add_cmd(32'hFFFF_FFFF, 48'h8000_0000_0000, 1'b0);
    add_cmd(32'h0000_0000, 48'h0000_0000_0005, 1'b0);
    add_cmd(32'h7FFF_FFFF, 48'h0000_0000_0002, 1'b0);
    add_cmd(32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0);
    add_cmd(32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b0);
    add_cmd(32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
    add_cmd(32'h0000_0001, 48'h0000_0000_0000, 1'b0);
    add_cmd(32'h8000_0000, 48'h0000_0000_0000, 1'b0);
    add_cmd(32'h5555_5555, 48'h0000_0000_0000, 1'b0);
    add_cmd(32'h0000_0001, 48'hFFFF_FFFF_FFFF, 1'b0);
    add_cmd(32'hFFFF_FFFE, 48'h0000_0000_0003, 1'b0);

    // Random part: a pool a bit larger than the table, so the table fills and
    // then mixes hits with evictions. Small time steps, often zero, give ties.
    pool[0] = 32'h0000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < POOL_SIZE; k++) begin
      pool[k] = $urandom();
    end
    clock_ms = 48'd100;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        clock_ms = clock_ms + 48'($urandom_range(2));
      end else if (roll < 88) begin
        clock_ms = clock_ms - 48'($urandom_range(50));
      end else begin
        clock_ms = {16'($urandom()), 32'($urandom())};
      end
      if ($urandom_range(99) < 85) begin
        sid = pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        sid = $urandom();
      end
      add_cmd(sid, clock_ms, (n == 120) || (n == 300));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (lookup_due.size() != 0) @(posedge clk);
    repeat (NUM_ENTRIES + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sltt_pkg.sv
rtl/sltt_cell.sv
rtl/session_lru_tag_table_core.sv
dv/session_lru_tag_table_core_test.sv
